>>> design/lfpd_pkg.sv
package lfpd_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned TickBits   = 16;
  localparam int unsigned GainBits   = 10;
  localparam int unsigned SpeedBits  = 11;
  localparam int unsigned DutyBits   = 12;
  localparam int unsigned PosBits    = 4;
  localparam int unsigned MagBits    = 4;   // |position difference| <= 10
  localparam int unsigned PropBits   = 13;  // gain * 5
  localparam int unsigned DerBits    = 14;  // gain * 10
  localparam int unsigned DriveBits  = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 11;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ON_THRESHOLD = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_BASE_SPEED   = 3'd3
  } reg_idx_e;

  localparam logic [SampleBits-1:0] RstOnThreshold = SampleBits'(200);
  localparam logic [GainBits-1:0]   RstPropGain    = GainBits'(140);
  localparam logic [GainBits-1:0]   RstDerivGain   = GainBits'(11);
  localparam logic [SpeedBits-1:0]  RstBaseSpeed   = SpeedBits'(568);

  localparam logic signed [PosBits-1:0] PosCenter   = 4'sd0;
  localparam logic signed [PosBits-1:0] PosLeft     = 4'sd1;
  localparam logic signed [PosBits-1:0] PosRight    = -4'sd1;
  localparam logic signed [PosBits-1:0] PosLostPos  = 4'sd5;
  localparam logic signed [PosBits-1:0] PosLostNeg  = -4'sd5;

  localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

>>> design/line_follow_pd_steering.sv
// Two-sensor PD line-follower steering.
// Input channel (in_valid_i/in_ready_o): one word carries a left and a right
// sensor sample. Output channel (out_valid_o/out_ready_i): one word per input
// word with the right and left motor duties and the coded line position.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 threshold, 1 prop gain, 2 deriv gain, 3 base speed); other indexes are
// ignored. Write only while the block is idle.
// Processing: after the input word is taken, a bit-serial divide runs (one
// quotient bit per cycle, the derivative gain accumulated as each bit comes
// out), then a step sums the drive terms and a last step clamps and loads the
// output register. A new word is taken only once the block is back in idle,
// so it is not taken before the last word is through.
// The output register holds a finished word while the receiver stalls; the
// next input word is still taken and worked on, and waits in the last step
// until the output register is free.
// Reset clears the position history, tick count and change parity and loads
// the registers with their defaults (200, 140, 11, 568).
module line_follow_pd_steering (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfpd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [lfpd_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lfpd_pkg::SampleBits-1:0]     left_sample_i,
  input  logic [lfpd_pkg::SampleBits-1:0]     right_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lfpd_pkg::DutyBits-1:0]       right_duty_o,
  output logic [lfpd_pkg::DutyBits-1:0]       left_duty_o,
  output logic signed [lfpd_pkg::PosBits-1:0] line_position_o
);

  lfpd_pkg::state_e state_q, state_d;

  logic [lfpd_pkg::SampleBits-1:0] thr_q;
  logic [lfpd_pkg::GainBits-1:0]   kp_q;
  logic [lfpd_pkg::GainBits-1:0]   kd_q;
  logic [lfpd_pkg::SpeedBits-1:0]  base_q;

  logic signed [lfpd_pkg::PosBits-1:0] prev_q;
  logic [lfpd_pkg::TickBits-1:0]       tick_q;
  logic                                parity_q;

  logic signed [lfpd_pkg::PosBits-1:0] pos_q;
  logic                                dneg_q;
  logic [lfpd_pkg::MagBits-1:0]        mag_q;
  logic [lfpd_pkg::MagBits-1:0]        rem_q;
  logic [lfpd_pkg::TickBits-1:0]       div_q;
  logic [lfpd_pkg::DerBits-1:0]        acc_q;
  logic [1:0]                          cnt_q;
  logic signed [lfpd_pkg::DriveBits-1:0] drive_q;

  logic                                out_valid_q;
  logic [lfpd_pkg::DutyBits-1:0]       rduty_q, lduty_q;
  logic signed [lfpd_pkg::PosBits-1:0] opos_q;

  // accept-time decode
  logic                                in_acc;
  logic                                lon, ron;
  logic signed [lfpd_pkg::PosBits-1:0] pos_new;
  logic signed [lfpd_pkg::PosBits:0]   diff;
  logic [lfpd_pkg::PosBits:0]          diff_abs;
  logic [lfpd_pkg::TickBits-1:0]       tick_inc;

  assign in_acc = in_valid_i && in_ready_o;
  assign lon    = left_sample_i >= thr_q;
  assign ron    = right_sample_i >= thr_q;

  always_comb begin
    if (lon && ron) begin
      pos_new = lfpd_pkg::PosCenter;
    end else if (lon) begin
      pos_new = lfpd_pkg::PosLeft;
    end else if (ron) begin
      pos_new = lfpd_pkg::PosRight;
    end else begin
      pos_new = prev_q[lfpd_pkg::PosBits-1] ? lfpd_pkg::PosLostNeg : lfpd_pkg::PosLostPos;
    end
  end

  assign diff     = 5'(pos_new) - 5'(prev_q);
  assign diff_abs = diff[lfpd_pkg::PosBits] ? 5'(-diff) : 5'(diff);
  assign tick_inc = (tick_q == lfpd_pkg::TickMax) ? tick_q : tick_q + 1'b1;

  // one restoring divide step
  logic [lfpd_pkg::MagBits:0]   rsh;
  logic                         qbit;
  logic [lfpd_pkg::MagBits:0]   rsub;
  logic [lfpd_pkg::DerBits-1:0] acc_d;

  assign rsh   = {rem_q, mag_q[lfpd_pkg::MagBits-1]};
  assign qbit  = {{(lfpd_pkg::TickBits-lfpd_pkg::MagBits-1){1'b0}}, rsh} >= div_q;
  assign rsub  = rsh - div_q[lfpd_pkg::MagBits:0];
  assign acc_d = {acc_q[lfpd_pkg::DerBits-2:0], 1'b0}
               + (qbit ? {{(lfpd_pkg::DerBits-lfpd_pkg::GainBits){1'b0}}, kd_q}
                       : '0);

  // drive terms
  logic [lfpd_pkg::PropBits-1:0]         pmag;
  logic signed [lfpd_pkg::DriveBits-1:0] pterm, dterm;

  always_comb begin
    if (pos_q == lfpd_pkg::PosLostPos || pos_q == lfpd_pkg::PosLostNeg) begin
      pmag = {1'b0, kp_q, 2'b00} + {3'b000, kp_q};
    end else if (pos_q == lfpd_pkg::PosLeft || pos_q == lfpd_pkg::PosRight) begin
      pmag = {3'b000, kp_q};
    end else begin
      pmag = '0;
    end
  end

  assign pterm = pos_q[lfpd_pkg::PosBits-1] ? -$signed({3'b000, pmag})
                                            : $signed({3'b000, pmag});
  assign dterm = dneg_q ? -$signed({2'b00, acc_q}) : $signed({2'b00, acc_q});

  // clamp and duties
  logic signed [lfpd_pkg::DriveBits-1:0] base_s, drive_c;
  logic signed [lfpd_pkg::DriveBits:0]   rsum, lsum;
  logic                                  out_free;

  assign base_s = $signed({{(lfpd_pkg::DriveBits-lfpd_pkg::SpeedBits){1'b0}}, base_q});

  always_comb begin
    if (drive_q > base_s) begin
      drive_c = base_s;
    end else if (drive_q < -base_s) begin
      drive_c = -base_s;
    end else begin
      drive_c = drive_q;
    end
  end

  assign rsum     = 17'(base_s) + 17'(drive_c);
  assign lsum     = 17'(base_s) - 17'(drive_c);
  assign out_free = !out_valid_q || out_ready_i;

  // control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      lfpd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = lfpd_pkg::ST_DIV;
        end
      end
      lfpd_pkg::ST_DIV: begin
        if (cnt_q == 2'd3) begin
          state_d = lfpd_pkg::ST_SUM;
        end
      end
      lfpd_pkg::ST_SUM: begin
        state_d = lfpd_pkg::ST_OUT;
      end
      lfpd_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = lfpd_pkg::ST_IDLE;
        end
      end
      default: state_d = lfpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= lfpd_pkg::RstOnThreshold;
      kp_q   <= lfpd_pkg::RstPropGain;
      kd_q   <= lfpd_pkg::RstDerivGain;
      base_q <= lfpd_pkg::RstBaseSpeed;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfpd_pkg::REG_ON_THRESHOLD: thr_q  <= cfg_data_i[lfpd_pkg::SampleBits-1:0];
        lfpd_pkg::REG_PROP_GAIN:    kp_q   <= cfg_data_i[lfpd_pkg::GainBits-1:0];
        lfpd_pkg::REG_DERIV_GAIN:   kd_q   <= cfg_data_i[lfpd_pkg::GainBits-1:0];
        lfpd_pkg::REG_BASE_SPEED:   base_q <= cfg_data_i[lfpd_pkg::SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  // loop history, updated when a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= lfpd_pkg::PosCenter;
      tick_q   <= '0;
      parity_q <= 1'b0;
    end else if (in_acc) begin
      prev_q <= pos_new;
      if (pos_new != prev_q && parity_q) begin
        // second change: restart the tick count
        tick_q   <= '0;
        parity_q <= 1'b0;
      end else begin
        tick_q <= tick_inc;
        if (pos_new != prev_q) begin
          parity_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q  <= pos_new;
      dneg_q <= diff[lfpd_pkg::PosBits];
      mag_q  <= diff_abs[lfpd_pkg::MagBits-1:0];
      div_q  <= tick_inc;
      rem_q  <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (state_q == lfpd_pkg::ST_DIV) begin
      mag_q <= {mag_q[lfpd_pkg::MagBits-2:0], 1'b0};
      rem_q <= qbit ? rsub[lfpd_pkg::MagBits-1:0] : rsh[lfpd_pkg::MagBits-1:0];
      acc_q <= acc_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == lfpd_pkg::ST_SUM) begin
      drive_q <= pterm + dterm;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lfpd_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lfpd_pkg::ST_OUT && out_free) begin
      rduty_q <= rsum[lfpd_pkg::DutyBits-1:0];
      lduty_q <= lsum[lfpd_pkg::DutyBits-1:0];
      opos_q  <= pos_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign right_duty_o    = rduty_q;
  assign left_duty_o     = lduty_q;
  assign line_position_o = opos_q;

endmodule

>>> test/line_follow_pd_steering_tb.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lfpd_pkg::DutyBits-1:0]       right_duty;
    logic [lfpd_pkg::DutyBits-1:0]       left_duty;
    logic signed [lfpd_pkg::PosBits-1:0] position;
  } steer_word_t;

  // indexes past the register list, must be ignored
  localparam logic [lfpd_pkg::CfgIdxBits-1:0] RegSpareFirst = 3'd4;
  localparam logic [lfpd_pkg::CfgIdxBits-1:0] RegSpareLast  = 3'd7;

  localparam int unsigned IdlePercent     = 19;
  localparam int unsigned WordsPerSetting = 215;
  localparam int unsigned SteadyWords     = 100;
  localparam int unsigned HoldOffCycles   = 300;
  localparam int unsigned SettleCycles    = 20;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [lfpd_pkg::CfgIdxBits-1:0]     cfg_idx;
  logic [lfpd_pkg::CfgBits-1:0]        cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [lfpd_pkg::SampleBits-1:0]     left_sample;
  logic [lfpd_pkg::SampleBits-1:0]     right_sample;
  logic                                out_valid;
  logic                                out_ready;
  logic [lfpd_pkg::DutyBits-1:0]       right_duty;
  logic [lfpd_pkg::DutyBits-1:0]       left_duty;
  logic signed [lfpd_pkg::PosBits-1:0] line_position;

  line_follow_pd_steering dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .right_duty_o   (right_duty),
    .left_duty_o    (left_duty),
    .line_position_o(line_position)
  );

  // steering predictor: registers and history
  logic [lfpd_pkg::SampleBits-1:0] cfg_thr;
  logic [lfpd_pkg::GainBits-1:0]   cfg_kp;
  logic [lfpd_pkg::GainBits-1:0]   cfg_kd;
  logic [lfpd_pkg::SpeedBits-1:0]  cfg_base;
  int                              last_pos;
  logic [lfpd_pkg::TickBits-1:0]   ticks;
  bit                              odd_change;

  steer_word_t expected_words[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned settings_used;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_left;

  function automatic steer_word_t predict_steering(
      input logic [lfpd_pkg::SampleBits-1:0] l,
      input logic [lfpd_pkg::SampleBits-1:0] r);
    steer_word_t w;
    bit          l_on;
    bit          r_on;
    int          pos;
    int          diff;
    int          rate;
    int          drive;
    int          base;
    l_on = (l >= cfg_thr);
    r_on = (r >= cfg_thr);
    base = int'(cfg_base);
    if (ticks != lfpd_pkg::TickMax) ticks = ticks + 1'b1;
    if (l_on && r_on) pos = lfpd_pkg::PosCenter;
    else if (l_on) pos = lfpd_pkg::PosLeft;
    else if (r_on) pos = lfpd_pkg::PosRight;
    else pos = (last_pos < 0) ? lfpd_pkg::PosLostNeg : lfpd_pkg::PosLostPos;
    diff = pos - last_pos;
    // magnitude divide, sign restored: truncates toward zero
    rate = ((diff < 0) ? -diff : diff) / int'(ticks);
    if (diff < 0) rate = -rate;
    drive = int'(cfg_kp) * pos + int'(cfg_kd) * rate;
    if (drive > base) drive = base;
    else if (drive < -base) drive = -base;
    w.right_duty = lfpd_pkg::DutyBits'(base + drive);
    w.left_duty  = lfpd_pkg::DutyBits'(base - drive);
    w.position   = lfpd_pkg::PosBits'(pos);
    if (pos != last_pos) begin
      if (odd_change) begin
        ticks      = '0;
        odd_change = 1'b0;
      end else begin
        odd_change = 1'b1;
      end
    end
    last_pos = pos;
    return w;
  endfunction

  function automatic logic [lfpd_pkg::SampleBits-1:0] pick_sample(input bit on_line);
    if (on_line || cfg_thr == '0)
      return lfpd_pkg::SampleBits'($urandom_range(1023, int'(cfg_thr)));
    return lfpd_pkg::SampleBits'($urandom_range(int'(cfg_thr) - 1, 0));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("line_follow_pd_steering regression: fail");
    $finish;
  end

  // receiver: random stalls plus an on-demand long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_idle_on) begin
        out_ready <= ($urandom_range(99, 0) >= IdlePercent);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    steer_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word right %0d left %0d pos %0d", $time,
                 right_duty, left_duty, line_position);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (right_duty !== want.right_duty) begin
          $display("%0t: right_duty expected %0d got %0d", $time, want.right_duty,
                   right_duty);
          errors++;
        end
        if (left_duty !== want.left_duty) begin
          $display("%0t: left_duty expected %0d got %0d", $time, want.left_duty, left_duty);
          errors++;
        end
        if (line_position !== want.position) begin
          $display("%0t: line_position expected %0d got %0d", $time, want.position,
                   line_position);
          errors++;
        end
      end
    end
  end

  // returns right after the accepting edge; caller drops valid or sends again
  task automatic send_samples(input logic [lfpd_pkg::SampleBits-1:0] l,
                              input logic [lfpd_pkg::SampleBits-1:0] r);
    @(negedge clk);
    if (tx_idle_on) begin
      while ($urandom_range(99, 0) < IdlePercent) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(predict_steering(l, r));
    words_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // entered at a falling edge with the block idle; leaves cfg_we high
  task automatic write_reg(input logic [lfpd_pkg::CfgIdxBits-1:0] idx,
                           input logic [lfpd_pkg::CfgBits-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      lfpd_pkg::REG_ON_THRESHOLD: cfg_thr  = data[lfpd_pkg::SampleBits-1:0];
      lfpd_pkg::REG_PROP_GAIN:    cfg_kp   = data[lfpd_pkg::GainBits-1:0];
      lfpd_pkg::REG_DERIV_GAIN:   cfg_kd   = data[lfpd_pkg::GainBits-1:0];
      lfpd_pkg::REG_BASE_SPEED:   cfg_base = data[lfpd_pkg::SpeedBits-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_steering(input int thr, input int kp, input int kd, input int base);
    wait_all_results();
    repeat (SettleCycles) @(negedge clk);
    write_reg(lfpd_pkg::REG_ON_THRESHOLD, lfpd_pkg::CfgBits'(thr));
    write_reg(lfpd_pkg::REG_PROP_GAIN, lfpd_pkg::CfgBits'(kp));
    write_reg(lfpd_pkg::REG_DERIV_GAIN, lfpd_pkg::CfgBits'(kd));
    write_reg(lfpd_pkg::REG_BASE_SPEED, lfpd_pkg::CfgBits'(base));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic test_line_codes();
    // defaults after reset, threshold edges, lost line on both sides of zero
    send_samples(10'd1023, 10'd1023);
    send_samples(10'd200, 10'd199);
    send_samples(10'd199, 10'd200);
    send_samples(10'd0, 10'd0);
    send_samples(10'd0, 10'd0);
    send_samples(10'd1023, 10'd0);
    send_samples(10'd0, 10'd0);
    send_samples(10'd0, 10'd1023);
    send_samples(10'd1023, 10'd1023);
    send_samples(10'd0, 10'd0);
    send_samples(10'd0, 10'd1023);
    send_samples(10'd0, 10'd0);
    send_samples(10'd512, 10'd0);
  endtask

  task automatic test_register_writes();
    wait_all_results();
    repeat (SettleCycles) @(negedge clk);
    // top data bit lies outside the 10-bit threshold and gain registers
    write_reg(lfpd_pkg::REG_ON_THRESHOLD, 11'h7FF);
    write_reg(lfpd_pkg::REG_PROP_GAIN, 11'h7FF);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, 11'h7FF);
    write_reg(lfpd_pkg::REG_BASE_SPEED, 11'd1024);
    write_reg(RegSpareFirst, 11'd0);
    write_reg(RegSpareLast, 11'd1);
    cfg_we <= 1'b0;
    settings_used++;
    send_samples(10'd1023, 10'd1022);
    send_samples(10'd1022, 10'd1023);
    send_samples(10'd0, 10'd0);
    send_samples(10'd1023, 10'd1023);
    set_steering(0, 0, 0, 1024);
    send_samples(10'd0, 10'd0);
    send_samples(10'd0, 10'd1023);
    set_steering(512, 1023, 1023, 0);
    send_samples(10'd0, 10'd1023);
    send_samples(10'd1023, 10'd0);
  endtask

  // a long steady run on the line lets the tick count grow large
  task automatic test_steady_run();
    set_steering(int'(lfpd_pkg::RstOnThreshold), int'(lfpd_pkg::RstPropGain),
                 int'(lfpd_pkg::RstDerivGain), int'(lfpd_pkg::RstBaseSpeed));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int unsigned i = 0; i < SteadyWords; i++)
      send_samples(pick_sample(1'b1), pick_sample(1'b1));
    repeat (3) send_samples(pick_sample(1'b1), pick_sample(1'b0));
    repeat (3) send_samples(pick_sample(1'b0), pick_sample(1'b0));
    repeat (3) send_samples(pick_sample(1'b0), pick_sample(1'b1));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_all_results();
    @(posedge clk);
    rx_hold_left = HoldOffCycles;
    for (int i = 0; i < 30; i++)
      send_samples(lfpd_pkg::SampleBits'($urandom()), lfpd_pkg::SampleBits'($urandom()));
    // sender pauses until everything is back
    wait_all_results();
  endtask

  task automatic send_position_runs(input int unsigned count);
    int unsigned done;
    int unsigned run_len;
    int unsigned code;
    done = 0;
    while (done < count) begin
      code    = $urandom_range(3, 0);
      run_len = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
      for (int unsigned i = 0; i < run_len && done < count; i++) begin
        if ($urandom_range(9, 0) == 0)
          send_samples(lfpd_pkg::SampleBits'($urandom()),
                       lfpd_pkg::SampleBits'($urandom()));
        else
          send_samples(pick_sample(code == 0 || code == 1), pick_sample(code == 0 || code == 2));
        done++;
      end
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_steering(int'(lfpd_pkg::RstOnThreshold), int'(lfpd_pkg::RstPropGain),
                        int'(lfpd_pkg::RstDerivGain), int'(lfpd_pkg::RstBaseSpeed));
        1: set_steering(0, 1023, 1023, 1024);
        2: set_steering(1023, 0, 0, 0);
        4: set_steering($urandom_range(1000, 20), $urandom_range(200, 0), 1023,
                        $urandom_range(64, 0));
        default: set_steering($urandom_range(1023, 1), $urandom_range(1023, 0),
                              $urandom_range(1023, 0), $urandom_range(1024, 0));
      endcase
      // one phase runs flat out on both sides
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      send_position_runs(WordsPerSetting);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = lfpd_pkg::REG_ON_THRESHOLD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    left_sample   = '0;
    right_sample  = '0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    settings_used = 1;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold_left  = 0;
    cfg_thr       = lfpd_pkg::RstOnThreshold;
    cfg_kp        = lfpd_pkg::RstPropGain;
    cfg_kd        = lfpd_pkg::RstDerivGain;
    cfg_base      = lfpd_pkg::RstBaseSpeed;
    last_pos      = 0;
    ticks         = '0;
    odd_change    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_line_codes();
    test_register_writes();
    test_output_backpressure();
    test_steady_run();
    test_random_settings();

    wait_all_results();
    repeat (SettleCycles) @(negedge clk);
    $display("covered %0d input words over %0d register settings, %0d results checked",
             words_sent, settings_used, words_checked);
    $display("incl. lost-line codes, threshold edges, long on-line run, output hold-off");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("line_follow_pd_steering regression: pass");
    end else begin
      $display("line_follow_pd_steering regression: fail");
    end
    $finish;
  end

endmodule
